// ----- hw/rtl/sit_pkg.sv -----
// Shared widths, stage payload types and helper functions for the segment intersection test.
`timescale 1ns / 1ps

package sit_pkg;

  // coordinate and register widths
  localparam int COORD_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // derived arithmetic widths
  localparam int DIFF_W  = COORD_W + 1;            // endpoint difference
  localparam int PROD_W  = 2 * DIFF_W;             // signed product of two differences
  localparam int CROSS_W = PROD_W + 1;             // cross product
  localparam int MAG_W   = CROSS_W - 1;            // cross product magnitude
  localparam int SQ_W    = 2 * COORD_W + 1;        // square of one difference
  localparam int LEN2_W  = SQ_W + 1;               // sum of two squares
  localparam int TOL2_W  = 2 * CFG_W;              // tolerance squared
  localparam int CSQ_W   = 2 * MAG_W;              // cross product squared
  localparam int TL_W    = TOL2_W + LEN2_W;        // tolerance squared times length squared
  localparam int CMP_W   = (CSQ_W > TL_W) ? CSQ_W : TL_W;
  localparam int PD_W    = (LEN2_W > TOL2_W) ? LEN2_W : TOL2_W;
  localparam int BB_W    = ((COORD_W > CFG_W) ? COORD_W : CFG_W) + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOLERANCE  = 1'b0,
    CFG_DEGEN_LEN2 = 1'b1
  } cfg_idx_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic signed [BB_W-1:0]    bb_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic [LEN2_W-1:0]         len2_t;
  typedef logic [TOL2_W-1:0]         tol2_t;
  typedef logic [CSQ_W-1:0]          csq_t;
  typedef logic [TL_W-1:0]           tl_t;
  typedef logic [CFG_W-1:0]          cfg_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
  } vec_t;

  // orientation sign: both clear means collinear within tolerance
  typedef struct packed {
    logic pos;
    logic neg;
  } orient_t;

  // stage 1: endpoints and differences
  typedef struct packed {
    point_t a;
    point_t b;
    point_t c;
    point_t d;
    vec_t   ba;
    vec_t   ca;
    vec_t   da;
    vec_t   dc;
    vec_t   ac;
    vec_t   bc;
  } s1_t;

  // stage 2: partial products, squares, box checks
  typedef struct packed {
    prod_t [3:0] xp_l;
    prod_t [3:0] xp_r;
    sq_t   [1:0] len_x2;
    sq_t   [1:0] len_y2;
    sq_t   [2:0] pt_x2;
    sq_t   [2:0] pt_y2;
    tol2_t       tol2;
    logic  [3:0] box_ok;
  } s2_t;

  // stage 3: orientations, magnitudes, squared lengths
  typedef struct packed {
    mag_t    [3:0] mag;
    orient_t [3:0] ori;
    len2_t   [1:0] len2;
    tol2_t         tol2;
    logic    [3:0] pt_ok;
    logic    [1:0] degen;
    logic    [3:0] box_ok;
  } s3_t;

  // stage 4: squared terms of the line distance test
  typedef struct packed {
    csq_t    [3:0] csq;
    tl_t     [1:0] tl;
    orient_t [3:0] ori;
    logic    [3:0] pt_ok;
    logic    [1:0] degen;
    logic    [3:0] box_ok;
  } s4_t;

  function automatic prod_t mul_s(input diff_t a, input diff_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  function automatic sq_t square(input diff_t a);
    prod_t p;
    p = mul_s(a, a);
    return p[SQ_W-1:0];
  endfunction

  // point p inside the box of segment s-e widened by tol
  function automatic logic in_box(input point_t p, input point_t s, input point_t e,
                                  input cfg_t tol);
    bb_t tt, px, py, sx, sy, ex, ey, lox, hix, loy, hiy;
    tt  = bb_t'(tol);
    px  = bb_t'(p.x);
    py  = bb_t'(p.y);
    sx  = bb_t'(s.x);
    sy  = bb_t'(s.y);
    ex  = bb_t'(e.x);
    ey  = bb_t'(e.y);
    lox = ((sx < ex) ? sx : ex) - tt;
    hix = ((sx > ex) ? sx : ex) + tt;
    loy = ((sy < ey) ? sy : ey) - tt;
    hiy = ((sy > ey) ? sy : ey) + tt;
    return (px >= lox) && (px <= hix) && (py >= loy) && (py <= hiy);
  endfunction

endpackage

// ----- hw/rtl/sit_diff.sv -----
// Stage 1: capture endpoints and form the coordinate differences.
`timescale 1ns / 1ps

module sit_diff import sit_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  logic   in_v,
  input  point_t a,
  input  point_t b,
  input  point_t c,
  input  point_t d,
  output logic   out_v,
  output s1_t    out_d
);

  logic v_r;
  s1_t  d_r;
  s1_t  d_nxt;

  function automatic vec_t sub_pt(input point_t p, input point_t q);
    vec_t r;
    r.x = diff_t'(p.x) - diff_t'(q.x);
    r.y = diff_t'(p.y) - diff_t'(q.y);
    return r;
  endfunction

  always_comb begin
    d_nxt.a  = a;
    d_nxt.b  = b;
    d_nxt.c  = c;
    d_nxt.d  = d;
    d_nxt.ba = sub_pt(b, a);
    d_nxt.ca = sub_pt(c, a);
    d_nxt.da = sub_pt(d, a);
    d_nxt.dc = sub_pt(d, c);
    d_nxt.ac = sub_pt(a, c);
    d_nxt.bc = sub_pt(b, c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign out_v = v_r;
  assign out_d = d_r;

endmodule

// ----- hw/rtl/sit_prod.sv -----
// Stage 2: cross product terms, squared differences and widened box checks.
`timescale 1ns / 1ps

module sit_prod import sit_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  cfg_t tol,
  input  logic in_v,
  input  s1_t  in_d,
  output logic out_v,
  output s2_t  out_d
);

  logic v_r;
  s2_t  d_r;
  s2_t  d_nxt;

  always_comb begin
    // orientation of c and d against a-b, of a and b against c-d
    d_nxt.xp_l[0] = mul_s(in_d.ba.x, in_d.ca.y);
    d_nxt.xp_r[0] = mul_s(in_d.ba.y, in_d.ca.x);
    d_nxt.xp_l[1] = mul_s(in_d.ba.x, in_d.da.y);
    d_nxt.xp_r[1] = mul_s(in_d.ba.y, in_d.da.x);
    d_nxt.xp_l[2] = mul_s(in_d.dc.x, in_d.ac.y);
    d_nxt.xp_r[2] = mul_s(in_d.dc.y, in_d.ac.x);
    d_nxt.xp_l[3] = mul_s(in_d.dc.x, in_d.bc.y);
    d_nxt.xp_r[3] = mul_s(in_d.dc.y, in_d.bc.x);
    d_nxt.len_x2[0] = square(in_d.ba.x);
    d_nxt.len_y2[0] = square(in_d.ba.y);
    d_nxt.len_x2[1] = square(in_d.dc.x);
    d_nxt.len_y2[1] = square(in_d.dc.y);
    // point distances: c-a (also a-c), d-a, b-c
    d_nxt.pt_x2[0] = square(in_d.ca.x);
    d_nxt.pt_y2[0] = square(in_d.ca.y);
    d_nxt.pt_x2[1] = square(in_d.da.x);
    d_nxt.pt_y2[1] = square(in_d.da.y);
    d_nxt.pt_x2[2] = square(in_d.bc.x);
    d_nxt.pt_y2[2] = square(in_d.bc.y);
    d_nxt.tol2 = tol2_t'(tol) * tol2_t'(tol);
    d_nxt.box_ok[0] = in_box(in_d.c, in_d.a, in_d.b, tol);
    d_nxt.box_ok[1] = in_box(in_d.d, in_d.a, in_d.b, tol);
    d_nxt.box_ok[2] = in_box(in_d.a, in_d.c, in_d.d, tol);
    d_nxt.box_ok[3] = in_box(in_d.b, in_d.c, in_d.d, tol);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign out_v = v_r;
  assign out_d = d_r;

endmodule

// ----- hw/rtl/sit_cross.sv -----
// Stage 3: cross products, orientation signs, squared lengths and point tests.
`timescale 1ns / 1ps

module sit_cross import sit_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  cfg_t tol,
  input  cfg_t degen_len2,
  input  logic in_v,
  input  s2_t  in_d,
  output logic out_v,
  output s3_t  out_d
);

  logic            v_r;
  s3_t             d_r;
  s3_t             d_nxt;
  cross_t          tol_w;
  cross_t    [3:0] xp;
  cross_t    [3:0] xp_abs;
  len2_t     [2:0] pd;
  logic      [2:0] pd_ok;

  always_comb begin
    tol_w = cross_t'(tol);
    for (int k = 0; k < 4; k++) begin
      xp[k]             = cross_t'(in_d.xp_l[k]) - cross_t'(in_d.xp_r[k]);
      d_nxt.ori[k].pos  = xp[k] > tol_w;
      d_nxt.ori[k].neg  = xp[k] < -tol_w;
      xp_abs[k]         = xp[k][CROSS_W-1] ? -xp[k] : xp[k];
      d_nxt.mag[k]      = xp_abs[k][MAG_W-1:0];
    end
    for (int s = 0; s < 2; s++) begin
      d_nxt.len2[s]  = len2_t'(in_d.len_x2[s]) + len2_t'(in_d.len_y2[s]);
      d_nxt.degen[s] = d_nxt.len2[s] <= len2_t'(degen_len2);
    end
    for (int p = 0; p < 3; p++) begin
      pd[p]    = len2_t'(in_d.pt_x2[p]) + len2_t'(in_d.pt_y2[p]);
      pd_ok[p] = PD_W'(pd[p]) <= PD_W'(in_d.tol2);
    end
    d_nxt.pt_ok  = {pd_ok[2], pd_ok[0], pd_ok[1], pd_ok[0]};
    d_nxt.tol2   = in_d.tol2;
    d_nxt.box_ok = in_d.box_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign out_v = v_r;
  assign out_d = d_r;

endmodule

// ----- hw/rtl/sit_square.sv -----
// Stage 4: squares of cross products and tolerance-scaled squared lengths.
`timescale 1ns / 1ps

module sit_square import sit_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic in_v,
  input  s3_t  in_d,
  output logic out_v,
  output s4_t  out_d
);

  logic v_r;
  s4_t  d_r;
  s4_t  d_nxt;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      d_nxt.csq[k] = csq_t'(in_d.mag[k]) * csq_t'(in_d.mag[k]);
    end
    for (int s = 0; s < 2; s++) begin
      d_nxt.tl[s] = tl_t'(in_d.tol2) * tl_t'(in_d.len2[s]);
    end
    d_nxt.ori    = in_d.ori;
    d_nxt.pt_ok  = in_d.pt_ok;
    d_nxt.degen  = in_d.degen;
    d_nxt.box_ok = in_d.box_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign out_v = v_r;
  assign out_d = d_r;

endmodule

// ----- hw/rtl/segment_intersection_test.sv -----
// Top level: config registers, four-stage datapath and the result register.
// Path: an accepted transfer passes five registers (differences, products, cross/sign,
//   squares, result) before its result shows on out_*; a held result stalls them all.
// Throughput: one segment pair per cycle; the pipeline holds only while a result waits.
// Reset (rst_n low, synchronous): all stage valid bits clear, tolerance and
//   degenerate_length_squared return to 0; payload registers are not reset.
`timescale 1ns / 1ps

module segment_intersection_test import sit_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  coord_t               in_first_start_x,
  input  coord_t               in_first_start_y,
  input  coord_t               in_first_end_x,
  input  coord_t               in_first_end_y,
  input  coord_t               in_second_start_x,
  input  coord_t               in_second_start_y,
  input  coord_t               in_second_end_x,
  input  coord_t               in_second_end_y,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_intersects,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // configuration registers; written only while the pipeline is empty is a user rule, not enforced here
  cfg_t tol_r;
  cfg_t degen_len2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r        <= '0;
      degen_len2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TOLERANCE:  tol_r        <= cfg_wdata;
        CFG_DEGEN_LEN2: degen_len2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Whole pipe advances together; it only freezes when the result register
  // holds a transfer the consumer is not taking.
  logic adv;
  logic out_valid_r;
  logic out_intersects_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  point_t pa, pb, pc, pd;

  assign pa = '{x: in_first_start_x,  y: in_first_start_y};
  assign pb = '{x: in_first_end_x,    y: in_first_end_y};
  assign pc = '{x: in_second_start_x, y: in_second_start_y};
  assign pd = '{x: in_second_end_x,   y: in_second_end_y};

  logic s1_v, s2_v, s3_v, s4_v;
  s1_t  s1_d;
  s2_t  s2_d;
  s3_t  s3_d;
  s4_t  s4_d;

  sit_diff u_diff (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .in_v  (in_valid),
    .a     (pa),
    .b     (pb),
    .c     (pc),
    .d     (pd),
    .out_v (s1_v),
    .out_d (s1_d)
  );

  sit_prod u_prod (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .tol   (tol_r),
    .in_v  (s1_v),
    .in_d  (s1_d),
    .out_v (s2_v),
    .out_d (s2_d)
  );

  sit_cross u_cross (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .tol        (tol_r),
    .degen_len2 (degen_len2_r),
    .in_v       (s2_v),
    .in_d       (s2_d),
    .out_v      (s3_v),
    .out_d      (s3_d)
  );

  sit_square u_square (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .in_v  (s3_v),
    .in_d  (s3_d),
    .out_v (s4_v),
    .out_d (s4_d)
  );

  // Final decision. Check k pairs orientation k with one endpoint:
  //   0: c on a-b, 1: d on a-b, 2: a on c-d, 3: b on c-d.
  // A point-like segment uses endpoint distance, otherwise the squared
  // line distance test cross^2 <= tol^2 * len^2.
  logic [3:0] line_ok;
  logic [3:0] on_seg;
  logic       proper_cross;
  logic       all_sided;
  logic       hit;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      line_ok[k] = s4_d.degen[k/2] ? s4_d.pt_ok[k]
                                   : (CMP_W'(s4_d.csq[k]) <= CMP_W'(s4_d.tl[k/2]));
      on_seg[k]  = (s4_d.ori[k] == '0) && line_ok[k] && s4_d.box_ok[k];
    end
    proper_cross = (s4_d.ori[0] != s4_d.ori[1]) && (s4_d.ori[2] != s4_d.ori[3]);
    all_sided    = (s4_d.ori[0] != '0) && (s4_d.ori[1] != '0)
                && (s4_d.ori[2] != '0) && (s4_d.ori[3] != '0);
    hit          = proper_cross || (|on_seg);
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_intersects_r <= hit;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_intersects = out_intersects_r;

  // a proper crossing always reports a hit
  a_cross_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v && adv && proper_cross) |=> (out_valid && out_intersects))
    else $error("proper crossing not reported as hit");

  // no collinear endpoint and no sign change means no hit
  a_sided_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v && adv && all_sided && !proper_cross) |=> (out_valid && !out_intersects))
    else $error("separated segments reported as hit");

  // input back-pressure only comes from a held result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // while the result is held, the last stage keeps its item
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(s4_v))
    else $error("pipeline moved while result was held");

endmodule
